// File: rtl/spq_pkg.sv
// Package for the stable priority queue: entry and command types, request codes, defaults.
package spq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int STAMP_W = 16;
    localparam int CUST_W = 8;
    localparam int PRIO_W = 8;
    localparam int LIMIT_W = 8;
    localparam int COUNT_OUT_W = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NOP     = 2'd3
    } req_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [CUST_W-1:0]  cust;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Broadcast to every cell of the chain, at most one of ins/ext/clr set.
    typedef struct packed {
        logic   ins;
        logic   ext;
        logic   clr;
        entry_t entry;
    } cell_cmd_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, inserts, shifts down, shifts up or clears.
module spq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t    prev_entry,
    input  logic               prev_valid,
    input  logic               prev_keep,
    input  spq_pkg::entry_t    next_entry,
    input  logic               next_valid,
    output spq_pkg::entry_t    entry,
    output logic               valid,
    output logic               keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // Ties stay ahead of the new entry, which keeps equal priorities in age order.
    assign keep = valid_reg && (entry_reg.prio >= cmd.entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.ins)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    entry_next = cmd.entry;
                    valid_next = 1'b1;
                end
                else
                begin
                    entry_next = prev_entry;
                    valid_next = prev_valid;
                end
            end
        end
        else if (cmd.ext)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: request decode, counters, cell chain, result register.
//
//  channel  | dir | transfer carries
//  ---------+-----+-------------------------------------------------------------
//  s_*      | in  | one request: tuser = req_type, tdata = stamp, customer, prio
//  m_*      | out | one result per request: tuser = done_res, tdata = entry+status
//  cfg_*    | in  | queue_limit write, taken on a rising edge with cfg_we high
//
//  Rate: one request per clock while the result side keeps up; every cell decides
//  locally from the broadcast command and its neighbors, so add, extract and clear all update every cell at once.
//  The result is registered; a request is taken while the previous result waits
//  as long as the sink takes that result in the same cycle.
//  Reset: async, active low; clears valid bits, count, result valid; limit -> 128.
//  Stalls: m_tready low with a result waiting holds it and stops input; nothing is lost.
module stable_priority_queue
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_stamp, [23:16] customer_id,
                                   // [31:24] priority_req
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] out_stamp, [23:16] out_customer,
                                   // [31:24] out_priority, [39:32] entry_count,
                                   // [40] queue_empty, [41] queue_full, rest zero
    output logic [0:0]  m_tuser,   // [0] done_res
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // queue_limit
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > spq_pkg::LIMIT_W) ? CW : spq_pkg::LIMIT_W;

    // ---------------------------------------------------------------- config
    logic [spq_pkg::LIMIT_W-1:0] limit_reg;
    logic [LW-1:0]               lim_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= spq_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Zero behaves as one, anything past the chain length as the chain length.
    always_comb
    begin
        lim_eff = LW'(limit_reg);
        if (limit_reg == '0)
        begin
            lim_eff = LW'(1);
        end
        else if (LW'(limit_reg) > LW'(DEPTH))
        begin
            lim_eff = LW'(DEPTH);
        end
    end

    // ---------------------------------------------------------------- decode
    logic               accept;
    spq_pkg::req_t      req;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done;
    spq_pkg::cell_cmd_t cmd;

    assign accept = s_tvalid && s_tready;
    assign req    = spq_pkg::req_t'(s_tuser);

    always_comb
    begin
        cmd.ins         = 1'b0;
        cmd.ext         = 1'b0;
        cmd.clr         = 1'b0;
        cmd.entry.stamp = s_tdata[15:0];
        cmd.entry.cust  = s_tdata[23:16];
        cmd.entry.prio  = s_tdata[31:24];
        done            = 1'b0;
        count_next      = count_reg;
        unique case (req)
            spq_pkg::REQ_ADD:
            begin
                if (LW'(count_reg) < lim_eff)
                begin
                    cmd.ins    = accept;
                    done       = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            spq_pkg::REQ_EXTRACT:
            begin
                if (count_reg != '0)
                begin
                    cmd.ext    = accept;
                    done       = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            spq_pkg::REQ_CLEAR:
            begin
                cmd.clr    = accept;
                done       = 1'b1;
                count_next = '0;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------- chain
    // Cell 0 holds the highest priority, oldest first among equals.
    spq_pkg::entry_t cell_entry [DEPTH];
    logic            cell_valid [DEPTH];
    logic            cell_keep  [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            spq_pkg::entry_t prev_e;
            logic            prev_v;
            logic            prev_k;
            spq_pkg::entry_t next_e;
            logic            next_v;

            if (gi == 0)
            begin : g_head
                // nothing ahead: the head takes the new entry unless it keeps its own
                assign prev_e = cmd.entry;
                assign prev_v = 1'b0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = cell_entry[gi-1];
                assign prev_v = cell_valid[gi-1];
                assign prev_k = cell_keep[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_e = cell_entry[gi];
                assign next_v = 1'b0;
            end
            else
            begin : g_mid
                assign next_e = cell_entry[gi+1];
                assign next_v = cell_valid[gi+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .prev_valid (prev_v),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .next_valid (next_v),
                .entry      (cell_entry[gi]),
                .valid      (cell_valid[gi]),
                .keep       (cell_keep[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- result
    localparam int COUNT_OUT_W = spq_pkg::COUNT_OUT_W;

    logic                   out_valid_reg;
    logic                   done_reg;
    spq_pkg::entry_t        res_entry_reg;
    logic [COUNT_OUT_W-1:0] res_count_reg;
    logic                   res_empty_reg;
    logic                   res_full_reg;

    assign s_tready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            done_reg      <= done;
            // head of the chain is the extracted entry; zeros for every other request
            res_entry_reg <= (req == spq_pkg::REQ_EXTRACT && done) ? cell_entry[0] : '0;
            res_count_reg <= COUNT_OUT_W'(count_next);
            res_empty_reg <= (count_next == '0);
            res_full_reg  <= (LW'(count_next) >= lim_eff);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = done_reg;
    assign m_tdata  = {6'b0, res_full_reg, res_empty_reg, res_count_reg,
                       res_entry_reg.prio, res_entry_reg.cust, res_entry_reg.stamp};

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for stable_priority_queue: directed and random requests vs a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before the run is abandoned
    localparam int HOLD_CYCLES = 200;   // length of the long result-side hold-off

    // Expected content of one result transfer
    typedef struct packed {
        logic            done;
        spq_pkg::entry_t entry;
        logic [7:0]      count;
        logic            empty;
        logic            full;
    } queue_reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] request_stamp, [23:16] customer_id, [31:24] priority_req
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;   // [15:0] out_stamp, [23:16] out_customer, [31:24] out_priority,
                            // [39:32] entry_count, [40] queue_empty, [41] queue_full
    logic [0:0]  m_tuser;   // [0] done_res
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    stable_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the queue in arrival order, its fill, the limit
    // ------------------------------------------------------------------
    spq_pkg::entry_t model_entries [spq_pkg::DEPTH_DEF];
    int              model_count = 0;
    logic [7:0]      model_limit;
    queue_reply_t    predicted_replies [$];

    // Idling controls; written just after a rising edge, read at falling edges
    int tx_idle_pct;
    int rx_idle_pct = 72;
    int hold_request = 0;   // bumped by a test to ask for one long hold-off
    int hold_taken = 0;     // hold-offs already started by the result side
    int hold_left = 0;

    // Run statistics
    int mismatch_count = 0;
    int requests_sent;
    int replies_seen = 0;
    int limit_writes;
    int adds_dropped = 0;
    int entries_extracted = 0;
    int deepest_fill = 0;
    int quiet_cycles = 0;

    // Applies one request to the predicted queue and returns the reply it produces.
    // Limit 0 behaves as 1, anything above the depth as the depth.
    function automatic queue_reply_t serve_request(input spq_pkg::req_t kind,
                                                   input spq_pkg::entry_t item);
        queue_reply_t reply;
        int           lim;
        int           best;
        reply = '0;
        lim = (model_limit == 0) ? 1 :
              ((model_limit > spq_pkg::DEPTH_DEF) ? spq_pkg::DEPTH_DEF : model_limit);
        case (kind)
            spq_pkg::REQ_ADD:
            begin
                if (model_count < lim)
                begin
                    model_entries[model_count] = item;
                    model_count++;
                    reply.done = 1'b1;
                end
                else
                begin
                    adds_dropped++;
                end
            end
            spq_pkg::REQ_EXTRACT:
            begin
                if (model_count > 0)
                begin
                    // strict compare keeps the oldest of equal priorities
                    best = 0;
                    for (int i = 1; i < model_count; i++)
                    begin
                        if (model_entries[i].prio > model_entries[best].prio)
                            best = i;
                    end
                    reply.entry = model_entries[best];
                    for (int i = best; i < model_count - 1; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_count--;
                    reply.done = 1'b1;
                    entries_extracted++;
                end
            end
            spq_pkg::REQ_CLEAR:
            begin
                model_count = 0;
                reply.done = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (model_count > deepest_fill)
            deepest_fill = model_count;
        reply.count = 8'(model_count);
        reply.empty = (model_count == 0);
        reply.full = (model_count >= lim);
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0d ns: reply %0d, %s is %0h, expected %0h",
                     $time, replies_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every request transfer, checks every result
    // transfer, and runs the watchdog. Samples at the rising edge only.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_reply_t    want;
        spq_pkg::entry_t item;
        if (rst_n)
        begin
            // a result never belongs to a request taken on the same edge, so check first
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (predicted_replies.size() == 0)
                begin
                    report_mismatch("reply with nothing outstanding", m_tdata[31:0], '0);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tuser[0] !== want.done)
                        report_mismatch("done_res", 32'(m_tuser[0]), 32'(want.done));
                    if (m_tdata[15:0] !== want.entry.stamp)
                        report_mismatch("out_stamp", 32'(m_tdata[15:0]),
                                        32'(want.entry.stamp));
                    if (m_tdata[23:16] !== want.entry.cust)
                        report_mismatch("out_customer", 32'(m_tdata[23:16]),
                                        32'(want.entry.cust));
                    if (m_tdata[31:24] !== want.entry.prio)
                        report_mismatch("out_priority", 32'(m_tdata[31:24]),
                                        32'(want.entry.prio));
                    if (m_tdata[39:32] !== want.count)
                        report_mismatch("entry_count", 32'(m_tdata[39:32]), 32'(want.count));
                    if (m_tdata[40] !== want.empty)
                        report_mismatch("queue_empty", 32'(m_tdata[40]), 32'(want.empty));
                    if (m_tdata[41] !== want.full)
                        report_mismatch("queue_full", 32'(m_tdata[41]), 32'(want.full));
                    if (m_tdata[47:42] !== 6'd0)
                        report_mismatch("tdata padding", 32'(m_tdata[47:42]), 32'd0);
                end
            end

            if (s_tvalid && s_tready)
            begin
                item.stamp = s_tdata[15:0];
                item.cust = s_tdata[23:16];
                item.prio = s_tdata[31:24];
                predicted_replies.push_back(serve_request(spq_pkg::req_t'(s_tuser), item));
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d replies outstanding",
                         quiet_cycles, predicted_replies.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_request != hold_taken)
        begin
            hold_left = HOLD_CYCLES;
            hold_taken = hold_request;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // One request transfer. Gaps are random per tx_idle_pct; during a gap the
    // payload is scrambled to show that it is ignored while tvalid is low.
    task automatic send_request(input spq_pkg::req_t kind, input logic [15:0] stamp,
                                input logic [7:0] cust, input logic [7:0] prio);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            s_tuser <= 2'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {prio, cust, stamp};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // Mostly adds and extracts so the queue actually fills; half the priorities
    // come from a tiny range to force ties.
    task automatic send_random_request();
        int            pick;
        spq_pkg::req_t kind;
        logic [7:0]    prio;
        pick = $urandom_range(99);
        if (pick < 50)
            kind = spq_pkg::REQ_ADD;
        else if (pick < 85)
            kind = spq_pkg::REQ_EXTRACT;
        else if (pick < 90)
            kind = spq_pkg::REQ_CLEAR;
        else
            kind = spq_pkg::REQ_NOP;
        prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        send_request(kind, 16'($urandom), 8'($urandom), prio);
    endtask

    // Drop tvalid and wait until every predicted reply has been checked.
    // Result is registered, so the task idles on at the end to cover any late output.
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Limit writes only happen with the block idle
    task automatic write_limit(input logic [7:0] value);
        wait_for_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_limit = value;
        limit_writes++;
    endtask

    // Drains first so the last request is not offered again across the change
    task automatic set_idling(input int tx_pct, input int rx_pct);
        wait_for_drain();
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extract, clear and the unused code on an empty queue
    task automatic test_empty_queue_requests();
        send_request(spq_pkg::REQ_EXTRACT, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(spq_pkg::REQ_CLEAR, 16'h0000, 8'h00, 8'h00);
        send_request(spq_pkg::REQ_NOP, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    // Field extremes, a priority tie, no-op while holding entries, drain past empty
    task automatic test_field_extremes();
        send_request(spq_pkg::REQ_ADD, 16'hFFFF, 8'h00, 8'hFF);
        send_request(spq_pkg::REQ_ADD, 16'h0000, 8'hFF, 8'h00);
        send_request(spq_pkg::REQ_ADD, 16'h1234, 8'h5A, 8'h80);
        send_request(spq_pkg::REQ_ADD, 16'h4321, 8'hA5, 8'h80);
        send_request(spq_pkg::REQ_NOP, 16'hFFFF, 8'hFF, 8'hFF);
        repeat (5) send_request(spq_pkg::REQ_EXTRACT, 16'h0000, 8'h00, 8'h00);
    endtask

    task automatic test_clear_with_entries();
        send_request(spq_pkg::REQ_ADD, 16'h00A0, 8'h11, 8'h20);
        send_request(spq_pkg::REQ_ADD, 16'h00A1, 8'h22, 8'h30);
        send_request(spq_pkg::REQ_CLEAR, 16'h0000, 8'h00, 8'h00);
        send_request(spq_pkg::REQ_EXTRACT, 16'h0000, 8'h00, 8'h00);
    endtask

    // Limit 0 acts as 1; then a limit lowered beneath the fill
    task automatic test_limit_extremes();
        write_limit(8'd0);
        send_request(spq_pkg::REQ_ADD, 16'h0B01, 8'h01, 8'h10);
        send_request(spq_pkg::REQ_ADD, 16'h0B02, 8'h02, 8'h20);
        send_request(spq_pkg::REQ_EXTRACT, 16'h0000, 8'h00, 8'h00);
        write_limit(8'd3);
        for (int i = 0; i < 4; i++)
            send_request(spq_pkg::REQ_ADD, 16'(16'h0C00 + i), 8'(i), 8'(8'h40 - i));
        write_limit(8'd1);
        send_request(spq_pkg::REQ_ADD, 16'h0D00, 8'h77, 8'hFF);
        repeat (3) send_request(spq_pkg::REQ_EXTRACT, 16'h0000, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic(input logic [7:0] limit, input int count);
        write_limit(limit);
        repeat (count) send_random_request();
    endtask

    // Hold the result side for a long stretch while requests keep coming
    task automatic test_backpressure();
        write_limit(8'd10);
        @(posedge clk);
        hold_request++;
        repeat (40) send_random_request();
    endtask

    // Limit above the depth acts as the depth: fill to it, overflow, drain past empty
    task automatic test_fill_to_depth();
        logic [7:0] prio;
        write_limit(8'd255);
        repeat (spq_pkg::DEPTH_DEF + 3)
        begin
            prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            send_request(spq_pkg::REQ_ADD, 16'($urandom), 8'($urandom), prio);
        end
        repeat (spq_pkg::DEPTH_DEF + 3)
            send_request(spq_pkg::REQ_EXTRACT, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        model_limit = spq_pkg::LIMIT_RESET;
        tx_idle_pct = 20;
        requests_sent = 0;
        limit_writes = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // busy sender, heavily stalled receiver
        set_idling(20, 72);
        test_empty_queue_requests();
        test_field_extremes();
        test_clear_with_entries();
        test_limit_extremes();
        test_random_traffic(8'd6, 40);

        // busy receiver, sparse sender
        set_idling(72, 20);
        test_random_traffic(8'd200, 40);
        test_random_traffic(8'd17, 30);

        // back to back on both sides
        set_idling(0, 0);
        test_backpressure();
        test_fill_to_depth();
        test_random_traffic(8'd128, 40);

        wait_for_drain();

        $display("Run covered %0d requests and %0d replies over %0d limit writes,",
                 requests_sent, replies_seen, limit_writes);
        $display("with %0d adds dropped, %0d entries extracted, peak fill %0d.",
                 adds_dropped, entries_extracted, deepest_fill);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
